[src/etb_pkg.sv]
// Shared types and constants for the event timer bank.
package etb_pkg;

    localparam int NUM_TIMERS  = 32;
    localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W       = 6;

    localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        FN_SET        = 3'd0,
        FN_UNSET      = 3'd1,
        FN_TAKE       = 3'd2,
        FN_TAKE_ALL   = 3'd3,
        FN_ADD        = 3'd4,
        FN_ADD_RELOAD = 3'd5,
        FN_DELETE     = 3'd6,
        FN_UPDATE     = 3'd7
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic                   load;
        logic                   exec;
        logic                   scan_step;
        logic [TIMER_IDX_W-1:0] scan_idx;
    } t_dp_cmd;

endpackage

[src/etb_ctrl.sv]
// Controller state machine: sequences accept, execute, timer scan and result.
module etb_ctrl
    import etb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_is_update,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state                 r_state, n_state;
    logic [TIMER_IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.scan_idx = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = i_is_update ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_OUT;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (r_idx == TIMER_IDX_W'(NUM_TIMERS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

[src/etb_dp.sv]
// Datapath: timer tables, pending/periodic registers and result registers.
module etb_dp
    import etb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    input  logic [2:0]       i_func,
    input  logic [31:0]      i_event_mask,
    input  logic [31:0]      i_duration,
    input  logic [31:0]      i_current_time,
    output logic             o_ok,
    output logic [31:0]      o_taken_bits,
    output logic [31:0]      o_next_wait,
    output logic [CNT_W-1:0] o_active_count
);

    // captured command
    t_func       r_func;
    logic [31:0] r_mask, r_dur, r_now;

    logic [31:0]      r_pending, n_pending;
    logic [31:0]      r_periodic, n_periodic;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ok, n_ok;
    logic [31:0]      r_taken, n_taken;
    logic [31:0]      r_wait, n_wait;

    logic [31:0]      r_deadline  [NUM_TIMERS];
    logic [31:0]      r_remaining [NUM_TIMERS];
    logic [31:0]      r_reload    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_armed;

    logic                   good, in_bank;
    logic [4:0]             mask_idx;
    logic [TIMER_IDX_W-1:0] addr;
    logic [31:0]            rd_rem, rd_dl, rd_rel, scan_bit;
    logic                   rd_armed, rd_per;
    logic [31:0]            past, ahead, dl_eff;

    logic             we_rem, we_dl, we_armed, we_rel;
    logic [31:0]      wd_rem, wd_dl;
    logic             wd_armed;

    always_comb begin
        mask_idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_mask[i]) begin
                mask_idx = mask_idx | 5'(i);
            end
        end
    end

    assign good    = (r_mask != '0) && ((r_mask & (r_mask - 32'd1)) == '0);
    assign in_bank = good && (32'(mask_idx) < 32'(NUM_TIMERS));
    assign addr    = i_cmd.scan_step ? i_cmd.scan_idx : mask_idx[TIMER_IDX_W-1:0];

    assign rd_rem   = r_remaining[addr];
    assign rd_dl    = r_deadline[addr];
    assign rd_rel   = r_reload[addr];
    assign rd_armed = r_armed[addr];
    assign rd_per   = r_periodic[addr];
    assign scan_bit = 32'd1 << addr;

    // unarmed entry: deadline would be rem + now, so now - deadline = -rem
    assign dl_eff = r_remaining[addr] + r_now;
    assign past   = rd_armed ? (r_now - rd_dl) : (32'd0 - rd_rem);
    assign ahead  = rd_armed ? (rd_dl - r_now) : rd_rem;

    always_comb begin
        n_pending  = r_pending;
        n_periodic = r_periodic;
        n_count    = r_count;
        n_ok       = r_ok;
        n_taken    = r_taken;
        n_wait     = r_wait;
        we_rem     = 1'b0;
        we_dl      = 1'b0;
        we_armed   = 1'b0;
        we_rel     = 1'b0;
        wd_rem     = '0;
        wd_dl      = '0;
        wd_armed   = 1'b0;

        if (i_cmd.load) begin
            // update result starts here; scan refines the wait
            n_ok    = 1'b1;
            n_taken = '0;
            n_wait  = (r_pending != '0) ? 32'd0 : ALL_ONES;
        end

        if (i_cmd.exec) begin
            n_ok    = 1'b0;
            n_taken = '0;
            n_wait  = '0;
            case (r_func)
                FN_SET: begin
                    if (good) begin
                        n_pending = r_pending | r_mask;
                        n_ok      = 1'b1;
                    end
                end
                FN_UNSET: begin
                    if (good) begin
                        n_pending = r_pending & ~r_mask;
                        n_ok      = 1'b1;
                    end
                end
                FN_TAKE: begin
                    if (good && ((r_pending & r_mask) != '0)) begin
                        n_pending = r_pending & ~r_mask;
                        n_ok      = 1'b1;
                    end
                end
                FN_TAKE_ALL: begin
                    n_taken   = r_pending;
                    n_pending = '0;
                    n_ok      = 1'b1;
                end
                FN_ADD: begin
                    if (r_dur == '0) begin
                        if (good) begin
                            n_pending = r_pending | r_mask;
                            n_ok      = 1'b1;
                        end
                    end else if (in_bank && (r_dur < HALF_RANGE)) begin
                        if (rd_rem == '0) begin
                            n_count = r_count + 1'b1;
                        end
                        we_armed = 1'b1;
                        we_rem   = 1'b1;
                        wd_rem   = r_dur;
                        n_ok     = 1'b1;
                    end
                end
                FN_ADD_RELOAD: begin
                    if (in_bank && (r_dur != '0) && (r_dur < HALF_RANGE)) begin
                        if (rd_rem == '0) begin
                            n_count  = r_count + 1'b1;
                            we_armed = 1'b1;
                            we_rem   = 1'b1;
                            wd_rem   = r_dur;
                        end
                        we_rel     = 1'b1;
                        n_periodic = r_periodic | r_mask;
                        n_ok       = 1'b1;
                    end
                end
                FN_DELETE: begin
                    if (in_bank) begin
                        if ((rd_rem != '0) && (r_count != '0)) begin
                            n_count = r_count - 1'b1;
                        end
                        we_armed   = 1'b1;
                        we_rem     = 1'b1;
                        n_periodic = r_periodic & ~r_mask;
                        n_pending  = r_pending & ~r_mask;
                        n_ok       = 1'b1;
                    end
                end
                default: begin
                    n_ok = 1'b1;
                end
            endcase
        end

        if (i_cmd.scan_step && (rd_rem != '0)) begin
            if (!rd_armed) begin
                we_dl    = 1'b1;
                wd_dl    = dl_eff;
                we_armed = 1'b1;
                wd_armed = 1'b1;
            end
            if (past < HALF_RANGE) begin
                n_wait    = '0;
                n_pending = n_pending | scan_bit;
                if (rd_per) begin
                    we_dl    = 1'b1;
                    wd_dl    = rd_rel + r_now;
                    we_armed = 1'b1;
                    wd_armed = 1'b1;
                end else begin
                    we_armed = 1'b1;
                    wd_armed = 1'b0;
                    we_rem   = 1'b1;
                    wd_rem   = '0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end else if ((r_wait != '0) && (ahead < r_wait)) begin
                n_wait = ahead;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_mask <= i_event_mask;
            r_dur  <= i_duration;
            r_now  <= i_current_time;
        end
        r_ok    <= n_ok;
        r_taken <= n_taken;
        r_wait  <= n_wait;
        if (we_dl) begin
            r_deadline[addr] <= wd_dl;
        end
        if (we_rel) begin
            r_reload[addr] <= r_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_periodic <= '0;
            r_count    <= '0;
            r_armed    <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_remaining[i] <= '0;
            end
        end else begin
            r_pending  <= n_pending;
            r_periodic <= n_periodic;
            r_count    <= n_count;
            if (we_armed) begin
                r_armed[addr] <= wd_armed;
            end
            if (we_rem) begin
                r_remaining[addr] <= wd_rem;
            end
        end
    end

    assign o_ok           = r_ok;
    assign o_taken_bits   = r_taken;
    assign o_next_wait    = r_wait;
    assign o_active_count = r_count;

endmodule

[src/event_timer_bank_top.sv]
// Top level of the event timer bank: stream ports, controller and datapath.
// One command per transfer, one result per command. For set, unset, take,
// take_all, add, add_reload and delete a command passes through the accept,
// execute and result states; for update the scan state takes the place of
// execute. The scan visits one timer entry per cycle through a single table
// port. A result stall holds the command in the result state. A new command
// is taken only after the previous result has been transferred.
module event_timer_bank_top
    import etb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // event_mask[31:0], duration[63:32], current_time[95:64]
    input  logic [2:0]   s_axis_tuser,   // func[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata    // ok[0], taken_bits[32:1], next_wait[64:33],
                                         // active_count[70:65], zero[71]
);

    t_dp_cmd          cmd;
    logic             ok;
    logic [31:0]      taken_bits, next_wait;
    logic [CNT_W-1:0] active_count;

    etb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_is_update (s_axis_tuser == FN_UPDATE),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    etb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (s_axis_tuser),
        .i_event_mask   (s_axis_tdata[31:0]),
        .i_duration     (s_axis_tdata[63:32]),
        .i_current_time (s_axis_tdata[95:64]),
        .o_ok           (ok),
        .o_taken_bits   (taken_bits),
        .o_next_wait    (next_wait),
        .o_active_count (active_count)
    );

    assign m_axis_tdata = {1'b0, active_count, next_wait, taken_bits, ok};

endmodule

[src/etb_checker.sv]
// Port-level checker for the event timer bank, bound to the top level.
module etb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // result held until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // one command in flight: no input while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("command not processed before next transfer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[70:65] <= 6'd32))
        else $error("active count out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind event_timer_bank_top etb_checker u_etb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb_event_timer_bank_top.sv]
// Self-checking testbench for the event timer bank: table of directed commands, then random.
`timescale 1ns / 100ps

module tb_event_timer_bank_top;
    import etb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // event_mask[31:0], duration[63:32], current_time[95:64]
    logic [2:0]  s_axis_tuser;   // func[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // ok[0], taken_bits[32:1], next_wait[64:33], active_count[70:65]

    typedef struct packed {
        logic        ok;
        logic [31:0] taken_bits;
        logic [31:0] next_wait;
        logic [5:0]  active_count;
    } t_result;

    typedef struct {
        t_func       fn;
        logic [31:0] mask;
        logic [31:0] dur;
        logic [31:0] now;
        logic        has_exp;
        t_result     exp;
    } t_row;

    // model of the timer bank state
    logic [31:0] m_pending;
    logic [31:0] m_periodic;
    logic [31:0] m_deadline [NUM_TIMERS];
    logic        m_armed    [NUM_TIMERS];
    logic [31:0] m_remain   [NUM_TIMERS];
    logic [31:0] m_reload   [NUM_TIMERS];
    logic [5:0]  m_running;

    t_result expected_q[$];
    int      n_errors;
    logic    stim_done;
    logic [31:0] sim_now;

    event_timer_bank_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_result timer_bank_predict(t_func fn, logic [31:0] mask,
                                                   logic [31:0] dur, logic [31:0] now);
        t_result     r;
        logic        one_hot;
        logic        in_bank;
        int          idx;
        logic [31:0] d;
        r = '0;
        one_hot = (mask != 0) && ((mask & (mask - 1)) == 0);
        idx = 0;
        for (int i = 31; i >= 0; i--)
            if (mask[i]) idx = i;
        in_bank = one_hot && (idx < NUM_TIMERS);
        case (fn)
            FN_SET: if (one_hot) begin
                m_pending |= mask;
                r.ok = 1'b1;
            end
            FN_UNSET: if (one_hot) begin
                m_pending &= ~mask;
                r.ok = 1'b1;
            end
            FN_TAKE: if (one_hot && (m_pending & mask) != 0) begin
                m_pending &= ~mask;
                r.ok = 1'b1;
            end
            FN_TAKE_ALL: begin
                r.taken_bits = m_pending;
                m_pending = '0;
                r.ok = 1'b1;
            end
            FN_ADD: begin
                if (dur == 0) begin
                    if (one_hot) begin
                        m_pending |= mask;
                        r.ok = 1'b1;
                    end
                end else if (in_bank && dur < HALF_RANGE) begin
                    if (m_remain[idx] == 0) m_running++;
                    m_armed[idx] = 1'b0;
                    m_deadline[idx] = '0;
                    m_remain[idx] = dur;
                    r.ok = 1'b1;
                end
            end
            FN_ADD_RELOAD: if (in_bank && dur != 0 && dur < HALF_RANGE) begin
                if (m_remain[idx] == 0) begin
                    m_running++;
                    m_armed[idx] = 1'b0;
                    m_deadline[idx] = '0;
                    m_remain[idx] = dur;
                end
                m_reload[idx] = dur;
                m_periodic |= mask;
                r.ok = 1'b1;
            end
            FN_DELETE: if (in_bank) begin
                if (m_remain[idx] != 0 && m_running != 0) m_running--;
                m_armed[idx] = 1'b0;
                m_deadline[idx] = '0;
                m_remain[idx] = '0;
                m_periodic &= ~mask;
                m_pending &= ~mask;
                r.ok = 1'b1;
            end
            default: begin
                r.ok = 1'b1;
                r.next_wait = (m_pending != 0) ? '0 : ALL_ONES;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (m_remain[i] != 0) begin
                        if (!m_armed[i]) begin
                            m_deadline[i] = m_remain[i] + now;
                            m_armed[i] = 1'b1;
                        end
                        if (32'(now - m_deadline[i]) < HALF_RANGE) begin
                            r.next_wait = '0;
                            m_pending[i] = 1'b1;
                            if (m_periodic[i]) begin
                                m_deadline[i] = m_reload[i] + now;
                            end else begin
                                m_armed[i] = 1'b0;
                                m_deadline[i] = '0;
                                m_remain[i] = '0;
                                if (m_running != 0) m_running--;
                            end
                        end else if (r.next_wait > 0) begin
                            d = m_deadline[i] - now;
                            if (d < r.next_wait) r.next_wait = d;
                        end
                    end
                end
            end
        endcase
        r.active_count = m_running;
        return r;
    endfunction

    task automatic send_cmd(t_func fn, logic [31:0] mask, logic [31:0] dur, logic [31:0] now,
                            logic has_exp, t_result exp);
        t_result pred;
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {now, dur, mask};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = timer_bank_predict(fn, mask, dur, now);
        if (has_exp && pred != exp) begin
            $error("directed row disagrees with predictor: exp %h pred %h", exp, pred);
            n_errors++;
        end
        expected_q.push_back(pred);
    endtask

    function automatic t_row row(t_func fn, logic [31:0] mask, logic [31:0] dur,
                                 logic [31:0] now, logic has_exp, t_result exp);
        t_row r;
        r.fn = fn; r.mask = mask; r.dur = dur; r.now = now;
        r.has_exp = has_exp; r.exp = exp;
        return r;
    endfunction

    // result checker with random stall
    initial begin
        t_result got;
        t_result exp;
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            got.ok           = m_axis_tdata[0];
            got.taken_bits   = m_axis_tdata[32:1];
            got.next_wait    = m_axis_tdata[64:33];
            got.active_count = m_axis_tdata[70:65];
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: %h", got);
                n_errors++;
            end else begin
                exp = expected_q.pop_front();
                if (got.ok !== exp.ok) begin
                    $error("ok: exp %0d got %0d", exp.ok, got.ok);
                    n_errors++;
                end
                if (got.taken_bits !== exp.taken_bits) begin
                    $error("taken_bits: exp %h got %h", exp.taken_bits, got.taken_bits);
                    n_errors++;
                end
                if (got.next_wait !== exp.next_wait) begin
                    $error("next_wait: exp %h got %h", exp.next_wait, got.next_wait);
                    n_errors++;
                end
                if (got.active_count !== exp.active_count) begin
                    $error("active_count: exp %0d got %0d", exp.active_count,
                           got.active_count);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_func fn;
        logic [31:0] mask, dur;
        int sel;
        n_errors = 0;
        stim_done = 1'b0;
        sim_now = 32'd0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FN_SET;
        m_pending = '0;
        m_periodic = '0;
        m_running = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            m_deadline[i] = '0; m_armed[i] = 1'b0; m_remain[i] = '0; m_reload[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        rows.push_back(row(FN_UPDATE, 0, 0, 0, 1, '{1'b1, 32'h0, ALL_ONES, 6'd0}));
        rows.push_back(row(FN_SET, 32'h0, 0, 0, 1, '{1'b0, 0, 0, 0}));
        rows.push_back(row(FN_SET, 32'h3, 0, 0, 1, '{1'b0, 0, 0, 0}));
        rows.push_back(row(FN_SET, 32'h8000_0000, 0, 0, 1, '{1'b1, 0, 0, 0}));
        rows.push_back(row(FN_TAKE, 32'h1, 0, 0, 1, '{1'b0, 0, 0, 0}));
        rows.push_back(row(FN_TAKE, 32'h8000_0000, 0, 0, 1, '{1'b1, 0, 0, 0}));
        rows.push_back(row(FN_ADD, 32'h10, 0, 0, 1, '{1'b1, 0, 0, 0}));
        rows.push_back(row(FN_UNSET, 32'h10, 0, 0, 1, '{1'b1, 0, 0, 0}));
        rows.push_back(row(FN_ADD, 32'h1, HALF_RANGE, 0, 1, '{1'b0, 0, 0, 0}));
        rows.push_back(row(FN_ADD, 32'h1, ALL_ONES, 0, 1, '{1'b0, 0, 0, 0}));
        rows.push_back(row(FN_ADD_RELOAD, 32'h2, 0, 0, 1, '{1'b0, 0, 0, 0}));
        rows.push_back(row(FN_ADD, 32'h1, 32'h7FFF_FFFE, 0, 1, '{1'b1, 0, 0, 6'd1}));
        rows.push_back(row(FN_ADD, 32'h1, 32'd5, 0, 1, '{1'b1, 0, 0, 6'd1}));
        rows.push_back(row(FN_ADD_RELOAD, 32'h2, 32'd3, 0, 1, '{1'b1, 0, 0, 6'd2}));
        rows.push_back(row(FN_ADD_RELOAD, 32'h1, 32'd7, 0, 0, '0));
        rows.push_back(row(FN_UPDATE, 0, 0, 32'hFFFF_FFFE, 0, '0));
        rows.push_back(row(FN_UPDATE, 0, 0, 32'h0000_0001, 0, '0));
        rows.push_back(row(FN_UPDATE, 0, 0, 32'h0000_0004, 0, '0));
        rows.push_back(row(FN_TAKE_ALL, ALL_ONES, ALL_ONES, ALL_ONES, 0, '0));
        rows.push_back(row(FN_DELETE, 32'h1, 0, 0, 0, '0));
        rows.push_back(row(FN_DELETE, 32'h1, 0, 0, 0, '0));
        rows.push_back(row(FN_DELETE, 32'h2, ALL_ONES, 0, 0, '0));
        rows.push_back(row(FN_UPDATE, ALL_ONES, ALL_ONES, ALL_ONES, 1,
                           '{1'b1, 0, ALL_ONES, 6'd0}));
        foreach (rows[k])
            send_cmd(rows[k].fn, rows[k].mask, rows[k].dur, rows[k].now,
                     rows[k].has_exp, rows[k].exp);
        s_axis_tvalid <= 1'b0;

        // hold off until the pipeline drains
        while (expected_q.size() != 0) @(posedge i_clk);

        for (int n = 0; n < 1700; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) fn = FN_UPDATE;
            else fn = t_func'($urandom_range(0, 6));
            // mostly well-formed one-hot masks, some noise
            if ($urandom_range(0, 9) < 8) mask = 32'h1 << $urandom_range(0, 31);
            else mask = $urandom();
            case ($urandom_range(0, 5))
                0: dur = 32'd0;
                1: dur = $urandom();
                2: dur = 32'h7FFF_FFFE - $urandom_range(0, 2) + $urandom_range(0, 2);
                default: dur = $urandom_range(1, 400);
            endcase
            sim_now = sim_now + $urandom_range(0, 120);
            if ($urandom_range(0, 49) == 0) sim_now = $urandom();
            send_cmd(fn, mask, dur, sim_now, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int drain;
        @(posedge stim_done);
        drain = 0;
        while (expected_q.size() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (50) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule
